>>> rtl/core/rtu_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// RTU frame receiver assertion macros
// Shared concurrent-check macros for the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef RTU_FRAME_RECEIVER_DEFINES_SVH
`define RTU_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RTUFR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtu frame receiver check failed");

// Next-cycle implication, disabled during reset.
`define RTUFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtu frame receiver check failed");

`endif

>>> rtl/core/rtufr_pkg.sv
// ----------------------------------------------------------------------------
// RTU frame receiver package
// Types, codes and default sizes shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package rtufr_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 256;
  localparam int TICKS_PER_MS_DEF    = 1000;

  localparam int GAP_W    = 18;
  localparam int MS_W     = 16;
  localparam int COUNT_W  = 9;
  localparam int CRC_W    = 16;
  localparam int CFG_W    = 18;
  localparam int CFG_IDX_W = 2;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Frame status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TIMEOUT   = 2'd1;
  localparam logic [1:0] ST_FRAME_ERR = 2'd2;
  localparam logic [1:0] ST_CRC_ERR   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_TO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_READ_TO  = 2'd2;

  localparam logic [GAP_W-1:0] CHAR_TO_RST  = 18'd2604;
  localparam logic [GAP_W-1:0] FRAME_TO_RST = 18'd4687;
  localparam logic [MS_W-1:0]  READ_TO_RST  = 16'd1000;
  localparam logic [CRC_W-1:0] CRC_PRESET   = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY     = 16'hA001;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WAIT    = 2'd1,
    PH_COLLECT = 2'd2,
    PH_CLOSE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic               item_kind;
    logic [7:0]         data_byte;
    logic [7:0]         byte_index;
    logic [1:0]         frame_status;
    logic [COUNT_W-1:0] frame_length;
  } out_item_t;

  typedef struct packed {
    logic [GAP_W-1:0] char_timeout_us;
    logic [GAP_W-1:0] frame_timeout_us;
    logic [MS_W-1:0]  read_timeout_ms;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [COUNT_W-1:0] byte_count;
  } ctrl_stat_t;

endpackage

>>> rtl/core/rtufr_crc.sv
// ----------------------------------------------------------------------------
// RTU frame receiver CRC step
// Folds one byte into the reflected CRC-16 residue (poly 0xA001).
// ----------------------------------------------------------------------------
module rtufr_crc (
  input  logic [rtufr_pkg::CRC_W-1:0] crc_in,
  input  logic [7:0]                  data,
  output logic [rtufr_pkg::CRC_W-1:0] crc_out
);

  always_comb begin
    logic [rtufr_pkg::CRC_W-1:0] c;
    c = crc_in ^ {8'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ rtufr_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

>>> rtl/core/rtufr_ctrl.sv
// ----------------------------------------------------------------------------
// RTU frame receiver control
// Phase machine, gap and millisecond timers, byte count and CRC residue.
// ----------------------------------------------------------------------------
module rtufr_ctrl #(
  parameter int MAX_FRAME_BYTES = rtufr_pkg::MAX_FRAME_BYTES_DEF,
  parameter int TICKS_PER_MS    = rtufr_pkg::TICKS_PER_MS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  rtufr_pkg::in_item_t    item,
  input  rtufr_pkg::cfg_t        cfg,
  output logic                   push,
  output rtufr_pkg::out_item_t   result,
  output rtufr_pkg::ctrl_stat_t  stat
);

  localparam int PRE_W = (TICKS_PER_MS < 1) ? 1 : $clog2(TICKS_PER_MS + 1);
  localparam logic [PRE_W-1:0] PRE_TOP = PRE_W'(TICKS_PER_MS);
  localparam logic [rtufr_pkg::COUNT_W-1:0] COUNT_TOP =
    rtufr_pkg::COUNT_W'(MAX_FRAME_BYTES);

  rtufr_pkg::phase_t                 phase, phase_next;
  logic [rtufr_pkg::GAP_W-1:0]       gap, gap_next;
  logic [PRE_W-1:0]                  pre, pre_next;
  logic [rtufr_pkg::MS_W-1:0]        ms, ms_next;
  logic [rtufr_pkg::COUNT_W-1:0]     count, count_next;
  logic [rtufr_pkg::CRC_W-1:0]       crc, crc_next;
  logic                              late, late_next;

  logic [rtufr_pkg::CRC_W-1:0]       crc_fed;
  logic [rtufr_pkg::GAP_W-1:0]       gap_inc;
  logic [PRE_W-1:0]                  pre_inc;
  logic                              pre_roll;
  logic [rtufr_pkg::MS_W-1:0]        ms_adv;
  logic [rtufr_pkg::COUNT_W-1:0]     count_inc;
  logic                              is_tick, is_byte, is_start;
  logic                              take_byte, ms_hit, char_over, frame_over;
  logic [1:0]                        fin_status;
  logic [rtufr_pkg::COUNT_W-1:0]     fin_length;

  rtufr_crc u_crc (
    .crc_in  (crc),
    .data    (item.rx_byte),
    .crc_out (crc_fed)
  );

  assign is_tick  = go && (item.command == rtufr_pkg::CMD_TICK);
  assign is_byte  = go && (item.command == rtufr_pkg::CMD_BYTE);
  assign is_start = go && (item.command == rtufr_pkg::CMD_START);

  // Saturating gap count and millisecond prescale
  assign gap_inc   = (&gap) ? gap : gap + 1'b1;
  assign pre_inc   = pre + 1'b1;
  assign pre_roll  = (pre_inc >= PRE_TOP);
  assign ms_adv    = (pre_roll && !(&ms)) ? ms + 1'b1 : ms;
  assign count_inc = count + 1'b1;

  assign take_byte  = is_byte && (phase == rtufr_pkg::PH_WAIT ||
                                  phase == rtufr_pkg::PH_COLLECT);
  assign ms_hit     = (ms_adv >= cfg.read_timeout_ms);
  assign char_over  = (gap_inc > cfg.char_timeout_us);
  assign frame_over = (gap_inc >= cfg.frame_timeout_us);

  // Closing verdict
  always_comb begin
    fin_length = '0;
    if (late) begin
      fin_status = rtufr_pkg::ST_FRAME_ERR;
    end else if (crc != '0) begin
      fin_status = rtufr_pkg::ST_CRC_ERR;
    end else begin
      fin_status = rtufr_pkg::ST_OK;
      fin_length = count;
    end
  end

  // Next state
  always_comb begin
    phase_next = phase;
    gap_next   = gap;
    pre_next   = pre;
    ms_next    = ms;
    count_next = count;
    crc_next   = crc;
    late_next  = late;
    if (is_start) begin
      phase_next = rtufr_pkg::PH_WAIT;
      gap_next   = '0;
      pre_next   = '0;
      ms_next    = '0;
      count_next = '0;
      crc_next   = rtufr_pkg::CRC_PRESET;
      late_next  = 1'b0;
    end else if (take_byte) begin
      count_next = count_inc;
      crc_next   = crc_fed;
      gap_next   = '0;
      phase_next = (count_inc >= COUNT_TOP) ? rtufr_pkg::PH_CLOSE : rtufr_pkg::PH_COLLECT;
    end else if (is_byte && phase == rtufr_pkg::PH_CLOSE) begin
      late_next = 1'b1;
    end else if (is_tick) begin
      case (phase)
        rtufr_pkg::PH_WAIT: begin
          pre_next = pre_roll ? '0 : pre_inc;
          ms_next  = ms_adv;
          if (ms_hit) begin
            phase_next = rtufr_pkg::PH_IDLE;
          end
        end
        rtufr_pkg::PH_COLLECT: begin
          gap_next = gap_inc;
          if (char_over) begin
            phase_next = frame_over ? rtufr_pkg::PH_IDLE : rtufr_pkg::PH_CLOSE;
          end
        end
        rtufr_pkg::PH_CLOSE: begin
          gap_next = gap_inc;
          if (frame_over) begin
            phase_next = rtufr_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Result for this transaction
  always_comb begin
    push   = 1'b0;
    result = '0;
    if (take_byte) begin
      push              = 1'b1;
      result.item_kind  = rtufr_pkg::KIND_DATA;
      result.data_byte  = item.rx_byte;
      result.byte_index = count[7:0];
    end else if (is_tick) begin
      case (phase)
        rtufr_pkg::PH_WAIT: begin
          if (ms_hit) begin
            push                = 1'b1;
            result.item_kind    = rtufr_pkg::KIND_STATUS;
            result.frame_status = rtufr_pkg::ST_TIMEOUT;
          end
        end
        rtufr_pkg::PH_COLLECT, rtufr_pkg::PH_CLOSE: begin
          if (frame_over && (char_over || phase == rtufr_pkg::PH_CLOSE)) begin
            push                = 1'b1;
            result.item_kind    = rtufr_pkg::KIND_STATUS;
            result.frame_status = fin_status;
            result.frame_length = fin_length;
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= rtufr_pkg::PH_IDLE;
      gap   <= '0;
      pre   <= '0;
      ms    <= '0;
      count <= '0;
      crc   <= rtufr_pkg::CRC_PRESET;
      late  <= 1'b0;
    end else begin
      phase <= phase_next;
      gap   <= gap_next;
      pre   <= pre_next;
      ms    <= ms_next;
      count <= count_next;
      crc   <= crc_next;
      late  <= late_next;
    end
  end

  assign stat.phase      = phase;
  assign stat.byte_count = count;

endmodule

>>> rtl/core/rtufr_out_buf.sv
// ----------------------------------------------------------------------------
// RTU frame receiver output buffer
// Output register plus one skid entry; full flag is registered.
// ----------------------------------------------------------------------------
module rtufr_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rtufr_pkg::out_item_t push_item,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rtufr_pkg::out_item_t out_item
);

  logic                 head_valid;
  rtufr_pkg::out_item_t head;
  logic                 skid_valid;
  rtufr_pkg::out_item_t skid;
  logic                 pop;

  assign pop = head_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= push;
      end else begin
        head_valid <= push;
      end
    end else if (!head_valid) begin
      head_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
        skid <= push_item;
      end else begin
        head <= push_item;
      end
    end else if (!head_valid) begin
      head <= push_item;
    end else if (push && !skid_valid) begin
      skid <= push_item;
    end
  end

  assign full      = head_valid && skid_valid;
  assign out_valid = head_valid;
  assign out_item  = head;

endmodule

>>> rtl/core/rtu_frame_receiver.sv
// ----------------------------------------------------------------------------
// RTU frame receiver
// Collects one serial RTU frame after a start command and reports it.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_item) carries events: a microsecond
// tick, a received byte or a start command. Output channel (out_valid /
// out_stall / out_item) carries one data item per frame byte, then one final
// status item whose length is zero on any error.
// Configuration: cfg_we writes cfg_data into register cfg_index (char timeout,
// frame timeout, read timeout); write only while the block is idle.
// Path: each input transaction passes through the input register, then the
// decision logic, into the output register.
// Throughput: one transaction per cycle unless the output buffer is full; the
// decision logic, including the byte-wide CRC fold, sits in one stage between
// the input register and the output register.
// Reset clears the phase to idle, zeroes the timers and count, presets the
// CRC and loads the default timeouts. No clearing pass is needed.
// When the receiver stalls, results pile into the output register and one
// skid entry; with both full, in_stall rises and the input register holds.
// ----------------------------------------------------------------------------
`include "rtu_frame_receiver_defines.svh"

module rtu_frame_receiver #(
  parameter int MAX_FRAME_BYTES = rtufr_pkg::MAX_FRAME_BYTES_DEF,
  parameter int TICKS_PER_MS    = rtufr_pkg::TICKS_PER_MS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rtufr_pkg::in_item_t               in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rtufr_pkg::out_item_t              out_item,
  input  logic                              cfg_we,
  input  logic [rtufr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtufr_pkg::CFG_W-1:0]       cfg_data
);

  // Input register
  logic                  s1_valid;
  rtufr_pkg::in_item_t   s1_item;
  logic                  s1_go;
  logic                  buf_full;

  // Configuration registers
  rtufr_pkg::cfg_t       cfg;

  logic                  push;
  rtufr_pkg::out_item_t  push_item;
  rtufr_pkg::ctrl_stat_t stat;

  // Advance the held transaction whenever the output side has room
  assign s1_go    = s1_valid && !buf_full;
  assign in_stall = s1_valid && buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.char_timeout_us  <= rtufr_pkg::CHAR_TO_RST;
      cfg.frame_timeout_us <= rtufr_pkg::FRAME_TO_RST;
      cfg.read_timeout_ms  <= rtufr_pkg::READ_TO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rtufr_pkg::REG_CHAR_TO:  cfg.char_timeout_us  <= cfg_data;
        rtufr_pkg::REG_FRAME_TO: cfg.frame_timeout_us <= cfg_data;
        rtufr_pkg::REG_READ_TO:  cfg.read_timeout_ms  <= cfg_data[rtufr_pkg::MS_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  rtufr_ctrl #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .TICKS_PER_MS    (TICKS_PER_MS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .go     (s1_go),
    .item   (s1_item),
    .cfg    (cfg),
    .push   (push),
    .result (push_item),
    .stat   (stat)
  );

  rtufr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // A start transaction always lands in the first-byte wait
  `RTUFR_ASSERT_NEXT(a_start_waits, clk, rst,
    s1_go && s1_item.command == rtufr_pkg::CMD_START, stat.phase == rtufr_pkg::PH_WAIT)

  // The byte count never passes the frame limit
  `RTUFR_ASSERT_NOW(a_count_bound, clk, rst, 1'b1,
    stat.byte_count <= rtufr_pkg::COUNT_W'(MAX_FRAME_BYTES))

  // Failed frames report zero length
  `RTUFR_ASSERT_NOW(a_err_len_zero, clk, rst,
    out_valid && out_item.item_kind == rtufr_pkg::KIND_STATUS &&
      out_item.frame_status != rtufr_pkg::ST_OK, out_item.frame_length == '0)

  // A status transaction always returns the control to idle
  `RTUFR_ASSERT_NEXT(a_status_idles, clk, rst,
    push && push_item.item_kind == rtufr_pkg::KIND_STATUS, stat.phase == rtufr_pkg::PH_IDLE)

endmodule

>>> verif/tb_rtu_frame_receiver.sv
// ----------------------------------------------------------------------------
// RTU frame receiver testbench
// Feeds tick, byte and start transactions into the receiver and mirrors its
// timing, CRC and status rules in a local predictor. Every data and status
// item that comes out is checked field by field, in order. Both handshakes
// get random gaps, and the receiver side also holds off for long stretches.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rtu_frame_receiver;
  import rtufr_pkg::*;

  localparam int          MAX_BYTES    = MAX_FRAME_BYTES_DEF;
  localparam int          TICKS_MS     = TICKS_PER_MS_DEF;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // One queued transaction for the sender: payload, idle cycles to wait
  // before offering it, and whether to hold it until all results are back.
  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          drain;
  } rx_event_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  rx_event_t   rx_events[$];     // transactions waiting to be offered
  out_item_t   due_outputs[$];   // predicted results, oldest first
  int unsigned queued_total = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;

  // Predictor copy of the timeout registers
  logic [GAP_W-1:0] cfg_char  = CHAR_TO_RST;
  logic [GAP_W-1:0] cfg_frame = FRAME_TO_RST;
  logic [MS_W-1:0]  cfg_read  = READ_TO_RST;

  // Predictor copy of the receiver state
  phase_t             rx_phase    = PH_IDLE;
  logic [GAP_W-1:0]   rx_gap      = '0;
  int unsigned        rx_prescale = 0;
  logic [MS_W-1:0]    rx_ms       = '0;
  logic [COUNT_W-1:0] rx_count    = '0;
  logic [CRC_W-1:0]   rx_crc      = CRC_PRESET;
  bit                 rx_late     = 1'b0;

  // Sender and receiver pacing
  int unsigned send_wait    = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  int unsigned results_seen = 0;
  bit          recv_calm    = 1'b0;
  out_item_t   rx_want;

  rtu_frame_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Modbus CRC-16, reflected, one byte at a time.
  function automatic logic [CRC_W-1:0] crc16_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
    logic [CRC_W-1:0] acc;
    acc = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    return acc;
  endfunction

  // Expect a final status item; the receiver drops back to idle with it.
  task automatic post_status(input logic [1:0] st, input logic [COUNT_W-1:0] len);
    out_item_t res;
    res              = '0;
    res.item_kind    = KIND_STATUS;
    res.frame_status = st;
    res.frame_length = len;
    due_outputs.push_back(res);
    rx_phase = PH_IDLE;
  endtask

  // Advance the predicted receiver by one accepted transaction.
  task automatic predict_rx_event(input in_item_t ev);
    out_item_t res;
    res = '0;
    if (ev.command == CMD_START) begin
      // Start restarts from any phase and never reports the dropped frame
      rx_phase    = PH_WAIT;
      rx_gap      = '0;
      rx_prescale = 0;
      rx_ms       = '0;
      rx_count    = '0;
      rx_crc      = CRC_PRESET;
      rx_late     = 1'b0;
    end else if (ev.command == CMD_BYTE && rx_phase == PH_CLOSE) begin
      // Bytes in the closing wait only spoil the frame
      rx_late = 1'b1;
    end else if (ev.command == CMD_BYTE && rx_phase != PH_IDLE) begin
      res.item_kind  = KIND_DATA;
      res.data_byte  = ev.rx_byte;
      res.byte_index = rx_count[7:0];
      due_outputs.push_back(res);
      rx_crc   = crc16_fold(rx_crc, ev.rx_byte);
      rx_count = rx_count + 1'b1;
      rx_gap   = '0;
      rx_phase = (rx_count >= MAX_BYTES) ? PH_CLOSE : PH_COLLECT;
    end else if (ev.command == CMD_TICK && rx_phase == PH_WAIT) begin
      rx_prescale++;
      if (rx_prescale >= TICKS_MS) begin
        rx_prescale = 0;
        if (rx_ms != '1) rx_ms++;
      end
      if (rx_ms >= cfg_read) post_status(ST_TIMEOUT, '0);
    end else if (ev.command == CMD_TICK && rx_phase != PH_IDLE) begin
      if (rx_gap != '1) rx_gap++;
      if (rx_phase == PH_COLLECT && rx_gap > cfg_char) rx_phase = PH_CLOSE;
      if (rx_phase == PH_CLOSE && rx_gap >= cfg_frame) begin
        if (rx_late) post_status(ST_FRAME_ERR, '0);
        else if (rx_crc != '0) post_status(ST_CRC_ERR, '0);
        else post_status(ST_OK, rx_count);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer queued transactions, predict each one as it is accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) predict_rx_event(in_item);
      // Hold the payload while stalled; otherwise the slot is free
      if (!in_valid || !in_stall) begin
        if (rx_events.size() != 0 && send_wait >= rx_events[0].gap &&
            !(rx_events[0].drain && due_outputs.size() != 0)) begin
          in_item  <= rx_events[0].item;
          in_valid <= 1'b1;
          void'(rx_events.pop_front());
          send_wait = 0;
        end else begin
          in_valid <= 1'b0;
          if (rx_events.size() != 0 && send_wait < rx_events[0].gap) send_wait++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result, pace the output stall
  // --------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [8:0] want,
                               input logic [8:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (due_outputs.size() == 0) begin
          $error("result with no expectation waiting: %h", out_item);
          mismatches++;
        end else begin
          rx_want = due_outputs.pop_front();
          compare_field("item_kind", rx_want.item_kind, out_item.item_kind);
          compare_field("data_byte", rx_want.data_byte, out_item.data_byte);
          compare_field("byte_index", rx_want.byte_index, out_item.byte_index);
          compare_field("frame_status", rx_want.frame_status, out_item.frame_status);
          compare_field("frame_length", rx_want.frame_length, out_item.frame_length);
        end
        results_seen++;
        // Switch between calm stretches and random stalls now and then
        if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
        stall_left = recv_calm ? 0 : $urandom_range(0, 9);
        // Long hold-off: let the block fill up and push back on its input
        if (results_seen % 150 == 75) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rtu_frame_receiver verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_event(input logic [1:0] cmd, input logic [7:0] b,
                             input bit burst, input bit drain);
    rx_event_t ev;
    ev.item.command = cmd;
    ev.item.rx_byte = b;
    ev.gap          = burst ? 0 : $urandom_range(0, 9);
    ev.drain        = drain;
    rx_events.push_back(ev);
    queued_total++;
  endtask

  task automatic queue_ticks(input int unsigned n, input bit burst);
    repeat (n) queue_event(CMD_TICK, $urandom, burst, 1'b0);
  endtask

  // Queue one start-to-status frame shaped from the current timeouts.
  // Length zero waits out the read timeout; length three and up carries a
  // valid CRC unless corrupted. A late byte, where the timeouts leave room, lands inside the closing wait.
  task automatic queue_frame(input int unsigned len, input bit corrupt,
                             input bit late, input bit burst, input bit drain);
    logic [CRC_W-1:0] run;
    logic [CRC_W-1:0] saved;
    logic [7:0]       b;
    int               close_n;
    int               late_at;
    queue_event(CMD_START, $urandom, burst, drain);
    if (len == 0) begin
      queue_ticks((cfg_read == 0) ? 1 : cfg_read * TICKS_MS, burst);
    end else begin
      if (cfg_read != 0) queue_ticks($urandom_range(0, 3), burst);
      run   = CRC_PRESET;
      saved = CRC_PRESET;
      for (int i = 0; i < len; i++) begin
        // Keep inner gaps within the character timeout
        if (i > 0) queue_ticks($urandom_range(0, (cfg_char < 4) ? cfg_char : 4), burst);
        if (i == len - 2) saved = run;
        if (len >= 3 && i == len - 2) b = saved[7:0];
        else if (len >= 3 && i == len - 1) b = saved[15:8];
        else b = $urandom;
        if (corrupt && i == len - 1) b = b ^ (8'h01 << $urandom_range(0, 7));
        run = crc16_fold(run, b);
        queue_event(CMD_BYTE, b, burst, 1'b0);
      end
      // A full frame closes on its own; otherwise the gap has to pass the
      // character timeout first
      if (len >= MAX_BYTES) close_n = (cfg_frame == 0) ? 1 : cfg_frame;
      else close_n = (cfg_frame > cfg_char + 1) ? cfg_frame : cfg_char + 1;
      late_at = -1;
      if (late) begin
        if (len >= MAX_BYTES) late_at = $urandom_range(0, close_n - 1);
        else if (cfg_frame > cfg_char + 1)
          late_at = $urandom_range(cfg_char + 1, cfg_frame - 1);
      end
      for (int k = 0; k < close_n; k++) begin
        if (k == late_at) queue_event(CMD_BYTE, $urandom, burst, 1'b0);
        queue_event(CMD_TICK, $urandom, burst, 1'b0);
      end
    end
  endtask

  task automatic queue_noise(input bit burst);
    repeat ($urandom_range(1, 8)) queue_event($urandom_range(0, 3), $urandom, burst, 1'b0);
  endtask

  // Wait until every transaction is in and every result is out, then give
  // transactions without a result time to leave the pipeline.
  task automatic wait_idle();
    while (rx_events.size() != 0 || in_valid || due_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timeouts(input logic [GAP_W-1:0] c, input logic [GAP_W-1:0] f,
                              input logic [MS_W-1:0] r);
    wait_idle();
    write_reg(REG_CHAR_TO, c);
    cfg_char = c;
    write_reg(REG_FRAME_TO, f);
    cfg_frame = f;
    write_reg(REG_READ_TO, {{(CFG_W - MS_W){1'b0}}, r});
    cfg_read = r;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned      rounds;
    int unsigned      random_items;
    int unsigned      before_n;
    int unsigned      len;
    int unsigned      pick;
    logic [GAP_W-1:0] c;
    logic [GAP_W-1:0] f;
    logic [MS_W-1:0]  r;
    bit               burst;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset timeouts: idle traffic is dropped, start aborts a frame silently
    queue_event(CMD_TICK, 8'h5A, 1'b0, 1'b0);
    queue_event(CMD_BYTE, 8'hA5, 1'b0, 1'b0);
    queue_event(2'd3, 8'hFF, 1'b0, 1'b0);
    queue_event(CMD_START, 8'h00, 1'b0, 1'b0);
    queue_event(2'd3, 8'h00, 1'b0, 1'b0);
    queue_event(CMD_BYTE, 8'h00, 1'b0, 1'b0);
    queue_event(CMD_BYTE, 8'hFF, 1'b1, 1'b0);
    queue_event(CMD_TICK, 8'h00, 1'b0, 1'b0);
    queue_event(CMD_START, 8'hFF, 1'b0, 1'b0);
    queue_event(CMD_BYTE, 8'h80, 1'b0, 1'b0);
    queue_event(CMD_START, 8'h01, 1'b0, 1'b0);

    // Zero timeouts: timeout on the first tick, status on the closing tick
    set_timeouts('0, '0, '0);
    queue_frame(0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_frame(1, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_frame(3, 1'b0, 1'b0, 1'b0, 1'b0);

    // Byte inside the closing wait gives a frame error
    set_timeouts(18'd1, 18'd5, '0);
    queue_frame(4, 1'b0, 1'b1, 1'b0, 1'b0);

    // Largest frame timeout: abort in the closing wait, then time out
    set_timeouts(18'd2, '1, '0);
    queue_event(CMD_START, 8'h11, 1'b0, 1'b0);
    queue_event(CMD_BYTE, 8'h01, 1'b0, 1'b0);
    queue_event(CMD_BYTE, 8'hFE, 1'b0, 1'b0);
    queue_ticks(3, 1'b0);
    queue_event(CMD_BYTE, 8'h7F, 1'b0, 1'b0);
    queue_event(CMD_START, 8'h22, 1'b0, 1'b0);
    queue_event(CMD_TICK, 8'h33, 1'b0, 1'b0);

    // Largest read timeout with an early first byte
    set_timeouts(18'd3, 18'd4, '1);
    queue_frame(3, 1'b0, 1'b0, 1'b0, 1'b0);

    // Millisecond prescaler: a restart clears it, then wait out one ms
    set_timeouts(18'd2, 18'd3, 16'd1);
    queue_event(CMD_START, $urandom, 1'b1, 1'b0);
    queue_ticks(500, 1'b1);
    queue_frame(0, 1'b0, 1'b0, 1'b1, 1'b0);

    // Random rounds: mostly well-formed frames with random content and
    // pacing, some corrupted or spoiled, the rest noise and aborted frames
    rounds       = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (rounds == 2) begin
        // Largest character timeout: only a full frame ends collection
        set_timeouts('1, $urandom_range(0, 12), '0);
        queue_frame(MAX_BYTES, 1'b0, 1'b0, 1'b0, 1'b1);
        queue_frame(MAX_BYTES, 1'b0, 1'b1, 1'b1, 1'b0);
      end else begin
        c = ($urandom_range(0, 7) == 0) ? '0 : $urandom_range(1, 6);
        f = $urandom_range(0, 12);
        case ($urandom_range(0, 2))
          0: r = '0;
          1: r = $urandom_range(1, 100);
          default: r = '1;
        endcase
        set_timeouts(c, f, r);
        if (rounds == 5) queue_frame(MAX_BYTES, 1'b1, 1'b1, 1'b0, 1'b1);
        for (int j = 0; j < 8; j++) begin
          burst = ($urandom_range(0, 3) == 0);
          len   = $urandom_range(1, 12);
          if (r == 0 && $urandom_range(0, 5) == 0) len = 0;
          before_n = queued_total;
          pick     = $urandom_range(0, 9);
          if (pick == 9) begin
            if ($urandom_range(0, 1) == 0) begin
              queue_noise(burst);
            end else begin
              // Aborted frame: the next start drops it
              queue_event(CMD_START, $urandom, burst, 1'b0);
              repeat ($urandom_range(1, 5)) queue_event(CMD_BYTE, $urandom, burst, 1'b0);
            end
          end else begin
            // First frame of each round waits for all results to drain
            queue_frame(len, pick == 7, pick == 8, burst, j == 0);
          end
          random_items += queued_total - before_n;
        end
      end
      rounds++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("rtu_frame_receiver verification clean");
    end else begin
      $display("rtu_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
